FILE: hw/rtl/qcer_pkg.sv
// Shared types and constants for the quadrature count extender and RPM unit.
package qcer_pkg;

    localparam int TOTAL_W     = 64;
    localparam int SPEED_W     = 48;
    localparam int RAW_W       = 16;
    localparam int TIME_W      = 32;
    localparam int CPR_W       = 16;
    localparam int DIVISOR_W   = CPR_W + TIME_W;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CPR_W-1:0] CPR_RESET     = 16'd1024;
    localparam logic [15:0]      MS_PER_MINUTE = 16'd60000;

    localparam logic [SPEED_W-1:0] SPEED_MAX_POS = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MAX_NEG = {1'b1, {(SPEED_W-1){1'b0}}};

    // Request commands
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS_PER_REV = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT         = 1'b1;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_PASS,
        OP_HELD,
        OP_CLEAR,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [RAW_W-1:0]  raw_count;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] total_count;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic                      speed_held;
    } result_t;

    typedef struct packed {
        logic [CPR_W-1:0] counts_per_rev;
        logic             invert_direction;
    } cfg_t;

    typedef struct packed {
        op_t                  op;
        logic [TOTAL_W-1:0]   total;
        logic [TOTAL_W-1:0]   diff;
        logic [DIVISOR_W-1:0] divisor;
    } entry_t;

endpackage

FILE: hw/rtl/qcer_front.sv
// Front end: extends the raw counter, tracks position and classifies each request.
module qcer_front #(
    parameter int RAW_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  qcer_pkg::item_t   item,
    input  qcer_pkg::cfg_t    cfg,
    output logic              push_valid,
    input  logic              push_ready,
    output qcer_pkg::entry_t  push_entry
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_EXT,
        F_CLS,
        F_PUSH
    } front_state_t;

    front_state_t state_reg;

    logic [qcer_pkg::CMD_W-1:0]     cmd_reg;
    logic [RAW_BITS-1:0]            raw_reg;
    logic [qcer_pkg::TIME_W-1:0]    now_reg;
    logic [RAW_BITS-1:0]            prev_raw_reg;
    logic [qcer_pkg::TOTAL_W-1:0]   total_reg;
    logic [qcer_pkg::TOTAL_W-1:0]   last_total_reg;
    logic [qcer_pkg::TIME_W-1:0]    last_time_reg;
    logic [qcer_pkg::TIME_W-1:0]    dt_reg;
    qcer_pkg::entry_t               entry_reg;

    logic [31:0]                    raw_wide;
    logic [RAW_BITS-1:0]            raw_step;
    logic signed [RAW_BITS:0]       delta_fwd;
    logic signed [RAW_BITS:0]       delta_dir;
    logic [qcer_pkg::TOTAL_W-1:0]   delta_ext;
    logic [qcer_pkg::TOTAL_W-1:0]   total_next;
    logic [qcer_pkg::TIME_W-1:0]    dt_next;
    logic [qcer_pkg::TOTAL_W-1:0]   diff_next;
    logic [qcer_pkg::DIVISOR_W-1:0] divisor_next;

    assign raw_wide   = 32'(item.raw_count);
    assign raw_step   = raw_reg - prev_raw_reg;
    assign delta_fwd  = $signed({raw_step[RAW_BITS-1], raw_step});
    assign delta_dir  = cfg.invert_direction ? -delta_fwd : delta_fwd;
    assign delta_ext  = qcer_pkg::TOTAL_W'(delta_dir);
    assign total_next = total_reg + delta_ext;
    assign dt_next    = now_reg - last_time_reg;
    assign diff_next  = total_reg - last_total_reg;
    assign divisor_next = qcer_pkg::DIVISOR_W'(cfg.counts_per_rev)
                        * qcer_pkg::DIVISOR_W'(dt_reg);

    assign item_ready = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            cmd_reg        <= qcer_pkg::CMD_COUNT;
            raw_reg        <= '0;
            now_reg        <= '0;
            prev_raw_reg   <= '0;
            total_reg      <= '0;
            last_total_reg <= '0;
            last_time_reg  <= '0;
            dt_reg         <= '0;
            entry_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (item_valid)
                    begin
                        cmd_reg   <= item.command;
                        raw_reg   <= raw_wide[RAW_BITS-1:0];
                        now_reg   <= item.now_ms;
                        state_reg <= F_EXT;
                    end
                end
                F_EXT:
                begin
                    total_reg    <= total_next;
                    prev_raw_reg <= raw_reg;
                    dt_reg       <= dt_next;
                    state_reg    <= F_CLS;
                end
                F_CLS:
                begin
                    entry_reg.diff    <= diff_next;
                    entry_reg.divisor <= divisor_next;
                    case (cmd_reg)
                        qcer_pkg::CMD_SPEED:
                        begin
                            entry_reg.total <= total_reg;
                            // zero elapsed time: keep speed state, report held speed
                            if (dt_reg == '0)
                            begin
                                entry_reg.op <= qcer_pkg::OP_HELD;
                            end
                            else
                            begin
                                entry_reg.op   <= qcer_pkg::OP_DIV;
                                last_time_reg  <= now_reg;
                                last_total_reg <= total_reg;
                            end
                        end
                        qcer_pkg::CMD_RESET:
                        begin
                            prev_raw_reg    <= '0;
                            total_reg       <= '0;
                            last_total_reg  <= '0;
                            entry_reg.total <= '0;
                            entry_reg.op    <= qcer_pkg::OP_PASS;
                        end
                        qcer_pkg::CMD_INIT:
                        begin
                            prev_raw_reg    <= '0;
                            total_reg       <= '0;
                            last_total_reg  <= '0;
                            last_time_reg   <= now_reg;
                            entry_reg.total <= '0;
                            entry_reg.op    <= qcer_pkg::OP_CLEAR;
                        end
                        default:
                        begin
                            entry_reg.total <= total_reg;
                            entry_reg.op    <= qcer_pkg::OP_PASS;
                        end
                    endcase
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // A reset or init request always hands on a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_PUSH
            && (cmd_reg == qcer_pkg::CMD_RESET || cmd_reg == qcer_pkg::CMD_INIT))
        |-> (entry_reg.total == '0 && total_reg == '0))
        else $error("reset request did not clear the position");

endmodule

FILE: hw/rtl/qcer_queue.sv
// Short in-order queue between the front end and the back end.
module qcer_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  qcer_pkg::entry_t  push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output qcer_pkg::entry_t  pop_entry
);

    localparam int PTR_W = (qcer_pkg::QUEUE_DEPTH > 1) ? $clog2(qcer_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(qcer_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(qcer_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(qcer_pkg::QUEUE_DEPTH);

    qcer_pkg::entry_t store_mem [qcer_pkg::QUEUE_DEPTH];
    qcer_pkg::entry_t head_reg;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready  = (count_reg != CNT_FULL);
    assign pop_valid   = (count_reg != '0);
    assign pop_entry   = head_reg;
    assign do_push     = push_valid && push_ready;
    assign do_pop      = pop_valid && pop_ready;
    assign rd_ptr_next = do_pop ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1)
                                : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= push_entry;
        end
        // a request pushed into an empty queue goes straight to the head
        if (do_push && wr_ptr_reg == rd_ptr_next)
        begin
            head_reg <= push_entry;
        end
        else
        begin
            head_reg <= store_mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/qcer_back.sv
// Back end: computes RPM with a restoring divider and delivers results in order.
module qcer_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  qcer_pkg::entry_t  pop_entry,
    output logic              result_valid,
    input  logic              result_ready,
    output qcer_pkg::result_t result
);

    localparam int SPEED_W    = qcer_pkg::SPEED_W;
    localparam int PART_W     = 32 + 16;
    localparam int PROD_W     = qcer_pkg::TOTAL_W + 16;
    localparam int DIVIDEND_W = PROD_W + FRAC_BITS;
    localparam int HIGH_W     = DIVIDEND_W - SPEED_W;
    localparam int STEP_W     = $clog2(SPEED_W + 1);

    typedef enum logic [3:0] {
        B_IDLE,
        B_MAG,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_CHECK,
        B_DIV,
        B_FIN,
        B_EMIT
    } back_state_t;

    back_state_t state_reg;

    logic [qcer_pkg::TOTAL_W-1:0]   total_reg;
    logic [qcer_pkg::TOTAL_W-1:0]   diff_reg;
    logic [qcer_pkg::DIVISOR_W-1:0] divisor_reg;
    logic                           neg_reg;
    logic [PART_W-1:0]              plo_reg;
    logic [PART_W-1:0]              phi_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [SPEED_W-1:0]             rem_reg;
    logic [SPEED_W-1:0]             low_reg;
    logic [SPEED_W-1:0]             quot_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [SPEED_W-1:0]             res_speed_reg;
    logic                           res_held_reg;
    logic [SPEED_W-1:0]             held_speed_reg;
    qcer_pkg::result_t              result_reg;
    logic                           result_valid_reg;

    logic [qcer_pkg::TOTAL_W-1:0]   mag_next;
    logic [PART_W-1:0]              mul_lo;
    logic [PART_W-1:0]              mul_hi;
    logic [PROD_W-1:0]              prod_next;
    logic [DIVIDEND_W-1:0]          dividend;
    logic [HIGH_W-1:0]              div_high;
    logic [SPEED_W-1:0]             div_low;
    logic                           high_ge;
    logic [SPEED_W:0]               trial;
    logic [SPEED_W:0]               trial_diff;
    logic                           trial_ge;
    logic [SPEED_W-1:0]             rem_step;
    logic [SPEED_W-1:0]             speed_fin;
    logic                           emit_go;

    assign mag_next  = diff_reg[qcer_pkg::TOTAL_W-1] ? -diff_reg : diff_reg;
    assign mul_lo    = PART_W'(diff_reg[31:0]) * PART_W'(qcer_pkg::MS_PER_MINUTE);
    assign mul_hi    = PART_W'(diff_reg[63:32]) * PART_W'(qcer_pkg::MS_PER_MINUTE);
    assign prod_next = PROD_W'(plo_reg) + {phi_reg, 32'b0};

    assign dividend  = DIVIDEND_W'(prod_reg) << FRAC_BITS;
    assign div_high  = dividend[DIVIDEND_W-1:SPEED_W];
    assign div_low   = dividend[SPEED_W-1:0];
    // high part at or above the divisor means the quotient overflows 48 bits
    assign high_ge   = (64'(div_high) >= 64'(divisor_reg));

    assign trial      = {rem_reg, low_reg[SPEED_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});
    assign rem_step   = trial_ge ? trial_diff[SPEED_W-1:0] : trial[SPEED_W-1:0];

    // hold until the output register is free
    assign emit_go = (state_reg == B_EMIT) && (!result_valid_reg || result_ready);

    always_comb
    begin
        if (neg_reg)
        begin
            speed_fin = (quot_reg > qcer_pkg::SPEED_MAX_NEG) ? qcer_pkg::SPEED_MAX_NEG
                                                             : -quot_reg;
        end
        else
        begin
            speed_fin = (quot_reg > qcer_pkg::SPEED_MAX_POS) ? qcer_pkg::SPEED_MAX_POS
                                                             : quot_reg;
        end
    end

    assign pop_ready    = (state_reg == B_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            total_reg        <= '0;
            diff_reg         <= '0;
            divisor_reg      <= '0;
            neg_reg          <= 1'b0;
            plo_reg          <= '0;
            phi_reg          <= '0;
            prod_reg         <= '0;
            rem_reg          <= '0;
            low_reg          <= '0;
            quot_reg         <= '0;
            step_reg         <= '0;
            res_speed_reg    <= '0;
            res_held_reg     <= 1'b0;
            held_speed_reg   <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        total_reg    <= pop_entry.total;
                        diff_reg     <= pop_entry.diff;
                        divisor_reg  <= pop_entry.divisor;
                        case (pop_entry.op)
                            qcer_pkg::OP_DIV:
                            begin
                                res_held_reg <= 1'b0;
                                state_reg    <= B_MAG;
                            end
                            qcer_pkg::OP_HELD:
                            begin
                                res_speed_reg <= held_speed_reg;
                                res_held_reg  <= 1'b1;
                                state_reg     <= B_EMIT;
                            end
                            qcer_pkg::OP_CLEAR:
                            begin
                                res_speed_reg <= '0;
                                res_held_reg  <= 1'b0;
                                state_reg     <= B_EMIT;
                            end
                            default:
                            begin
                                res_speed_reg <= held_speed_reg;
                                res_held_reg  <= 1'b0;
                                state_reg     <= B_EMIT;
                            end
                        endcase
                    end
                end
                B_MAG:
                begin
                    neg_reg   <= diff_reg[qcer_pkg::TOTAL_W-1];
                    diff_reg  <= mag_next;
                    state_reg <= B_MUL_LO;
                end
                B_MUL_LO:
                begin
                    plo_reg   <= mul_lo;
                    state_reg <= B_MUL_HI;
                end
                B_MUL_HI:
                begin
                    phi_reg   <= mul_hi;
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= B_CHECK;
                end
                B_CHECK:
                begin
                    if (diff_reg == '0)
                    begin
                        res_speed_reg <= '0;
                        state_reg     <= B_EMIT;
                    end
                    else if (divisor_reg == '0 || high_ge)
                    begin
                        res_speed_reg <= neg_reg ? qcer_pkg::SPEED_MAX_NEG
                                                 : qcer_pkg::SPEED_MAX_POS;
                        state_reg     <= B_EMIT;
                    end
                    else
                    begin
                        rem_reg   <= SPEED_W'(div_high);
                        low_reg   <= div_low;
                        quot_reg  <= '0;
                        step_reg  <= STEP_W'(SPEED_W);
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    rem_reg  <= rem_step;
                    low_reg  <= {low_reg[SPEED_W-2:0], 1'b0};
                    quot_reg <= {quot_reg[SPEED_W-2:0], trial_ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    res_speed_reg <= speed_fin;
                    state_reg     <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (emit_go)
                    begin
                        result_reg.total_count <= total_reg;
                        result_reg.speed_rpm   <= res_speed_reg;
                        result_reg.speed_held  <= res_held_reg;
                        held_speed_reg         <= res_speed_reg;
                        state_reg              <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.speed_rpm == held_speed_reg))
        else $error("waiting result disagrees with held speed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK && divisor_reg == '0 && diff_reg != '0)
        |=> (state_reg == B_EMIT
             && (res_speed_reg == qcer_pkg::SPEED_MAX_POS
                 || res_speed_reg == qcer_pkg::SPEED_MAX_NEG)))
        else $error("zero divisor did not saturate");

endmodule

FILE: hw/rtl/quadrature_count_extend_and_rpm.sv
// Top level of the quadrature count extender with RPM speed measurement.
// Every request extends the raw encoder counter into a 64-bit signed position and
// returns one result, in request order. The front end takes a request, extends the
// count and classifies it, then hands it through a two-entry queue to the back end,
// so a new request is taken while the back end still works or a result waits to be
// taken. Count, reset, init and held-speed requests skip the back-end arithmetic; a
// speed request with nonzero elapsed time passes through the 48-step restoring
// divider that forms
// position change * 60000 * 2^FRAC_BITS / (counts_per_rev * dt), which is skipped
// when the position did not move or the quotient would overflow 48 bits.
// Configuration is taken every cycle and must be written only while no
// request is in flight.
module quadrature_count_extend_and_rpm #(
    parameter int RAW_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  qcer_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output qcer_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qcer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qcer_pkg::CFG_DATA_W-1:0]     cfg_data
);

    qcer_pkg::cfg_t   cfg_reg;
    logic             push_valid;
    logic             push_ready;
    qcer_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    qcer_pkg::entry_t pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counts_per_rev   <= qcer_pkg::CPR_RESET;
            cfg_reg.invert_direction <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qcer_pkg::CFG_COUNTS_PER_REV:
                begin
                    cfg_reg.counts_per_rev <= cfg_data[qcer_pkg::CPR_W-1:0];
                end
                qcer_pkg::CFG_INVERT:
                begin
                    cfg_reg.invert_direction <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    qcer_front #(
        .RAW_BITS (RAW_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    qcer_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    qcer_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: test/position_speed_checker.sv
`timescale 1ns / 1ps
// Checker for the quadrature count extender: predicts every result and compares it.
module position_speed_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  qcer_pkg::item_t                  item,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  qcer_pkg::result_t                result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [qcer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qcer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               waiting
);

    localparam int REPORT_CAP = 100;

    logic [qcer_pkg::CPR_W-1:0]   cpr;
    logic                         invert;
    logic [qcer_pkg::RAW_W-1:0]   last_raw;
    logic [qcer_pkg::TOTAL_W-1:0] position;
    logic [qcer_pkg::TOTAL_W-1:0] mark_total;
    logic [qcer_pkg::TIME_W-1:0]  mark_time;
    logic [qcer_pkg::SPEED_W-1:0] rpm;
    qcer_pkg::result_t            predicted_readings[$];
    qcer_pkg::result_t            want;
    qcer_pkg::result_t            fresh;
    int                           mismatch_total;

    task automatic flag_mismatch(input string what,
                                 input logic [qcer_pkg::TOTAL_W-1:0] got,
                                 input logic [qcer_pkg::TOTAL_W-1:0] wanted);
        if (mismatch_total < REPORT_CAP)
            $display("MISMATCH %s at %0t: got %h, want %h", what, $time, got, wanted);
        mismatch_total++;
    endtask

    // Signed Q16 RPM from a count change and cpr*dt, truncated toward zero and clamped.
    function automatic logic [qcer_pkg::SPEED_W-1:0] rpm_q16(
        input logic [qcer_pkg::TOTAL_W-1:0]   moved,
        input logic [qcer_pkg::DIVISOR_W-1:0] divisor);
        logic                         neg;
        logic [qcer_pkg::TOTAL_W-1:0] mag;
        logic [127:0]                 quo;
        neg = moved[qcer_pkg::TOTAL_W-1];
        mag = neg ? -moved : moved;
        if (mag == '0)
            return '0;
        // zero divisor: clamp toward the sign of the movement
        if (divisor == '0)
            return neg ? qcer_pkg::SPEED_MAX_NEG : qcer_pkg::SPEED_MAX_POS;
        quo = ((128'(mag) * 128'(qcer_pkg::MS_PER_MINUTE)) << FRAC_BITS) / 128'(divisor);
        if (neg)
            return (quo > 128'(qcer_pkg::SPEED_MAX_NEG)) ? qcer_pkg::SPEED_MAX_NEG
                                                         : -quo[qcer_pkg::SPEED_W-1:0];
        return (quo > 128'(qcer_pkg::SPEED_MAX_POS)) ? qcer_pkg::SPEED_MAX_POS
                                                     : quo[qcer_pkg::SPEED_W-1:0];
    endfunction

    task automatic predict_reading(input qcer_pkg::item_t req,
                                   output qcer_pkg::result_t reading);
        logic [qcer_pkg::RAW_W-1:0]   wrap;
        logic [qcer_pkg::TOTAL_W-1:0] step;
        logic [qcer_pkg::TIME_W-1:0]  elapsed;
        logic                         held;
        wrap = req.raw_count - last_raw;
        step = {{(qcer_pkg::TOTAL_W-qcer_pkg::RAW_W){wrap[qcer_pkg::RAW_W-1]}}, wrap};
        if (invert)
            step = -step;
        last_raw = req.raw_count;
        position = position + step;
        held = 1'b0;
        case (req.command)
            qcer_pkg::CMD_SPEED:
            begin
                elapsed = req.now_ms - mark_time;
                if (elapsed == '0)
                    held = 1'b1;
                else
                begin
                    rpm = rpm_q16(position - mark_total,
                                  qcer_pkg::DIVISOR_W'(cpr)
                                  * qcer_pkg::DIVISOR_W'(elapsed));
                    mark_time = req.now_ms;
                    mark_total = position;
                end
            end
            qcer_pkg::CMD_RESET, qcer_pkg::CMD_INIT:
            begin
                last_raw = '0;
                position = '0;
                mark_total = '0;
                if (req.command == qcer_pkg::CMD_INIT)
                begin
                    mark_time = req.now_ms;
                    rpm = '0;
                end
            end
            default:
            begin
            end
        endcase
        reading.total_count = position;
        reading.speed_rpm = rpm;
        reading.speed_held = held;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr = qcer_pkg::CPR_RESET;
            invert = 1'b0;
            last_raw = '0;
            position = '0;
            mark_total = '0;
            mark_time = '0;
            rpm = '0;
            mismatch_total = 0;
            predicted_readings.delete();
            mismatches <= 0;
            waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qcer_pkg::CFG_COUNTS_PER_REV)
                    cpr = cfg_data[qcer_pkg::CPR_W-1:0];
                else if (cfg_index == qcer_pkg::CFG_INVERT)
                    invert = cfg_data[0];
            end
            // Retire the oldest prediction before queuing a new request.
            if (result_valid && result_ready)
            begin
                if (predicted_readings.size() == 0)
                    flag_mismatch("result with no request pending", result.total_count, '0);
                else
                begin
                    want = predicted_readings.pop_front();
                    if (result.total_count !== want.total_count)
                        flag_mismatch("total_count", result.total_count, want.total_count);
                    if (result.speed_rpm !== want.speed_rpm)
                        flag_mismatch("speed_rpm", qcer_pkg::TOTAL_W'(result.speed_rpm),
                                      qcer_pkg::TOTAL_W'(want.speed_rpm));
                    if (result.speed_held !== want.speed_held)
                        flag_mismatch("speed_held", qcer_pkg::TOTAL_W'(result.speed_held),
                                      qcer_pkg::TOTAL_W'(want.speed_held));
                end
            end
            if (item_valid && item_ready)
            begin
                predict_reading(item, fresh);
                predicted_readings.push_back(fresh);
            end
            waiting <= predicted_readings.size();
            mismatches <= mismatch_total;
        end
    end

endmodule

FILE: test/quadrature_count_extend_and_rpm_tb.sv
`timescale 1ns / 1ps
// Testbench top for the quadrature count extender: drives requests and configuration.
module quadrature_count_extend_and_rpm_tb;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 80;

    logic                             clk;
    logic                             rst_n;
    logic                             item_valid;
    logic                             item_ready;
    qcer_pkg::item_t                  item;
    logic                             result_valid;
    logic                             result_ready;
    qcer_pkg::result_t                result;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [qcer_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [qcer_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                               mismatches;
    int                               waiting;
    int                               cycle_count;
    bit                               steady_run;
    logic [qcer_pkg::RAW_W-1:0]       enc_raw;
    logic [qcer_pkg::TIME_W-1:0]      enc_ms;
    int                               enc_vel;

    quadrature_count_extend_and_rpm u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    position_speed_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        if (steady_run)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Hold valid between back-to-back requests; drop it only for a gap.
    task automatic send_request(input logic [qcer_pkg::CMD_W-1:0] cmd,
                                input logic [qcer_pkg::RAW_W-1:0] raw,
                                input logic [qcer_pkg::TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= '{command: cmd, raw_count: raw, now_ms: now};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Hold off new requests until every result is back, then let the block settle.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [qcer_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [qcer_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [qcer_pkg::CPR_W-1:0] cpr, input logic inv);
        drain();
        write_cfg(qcer_pkg::CFG_COUNTS_PER_REV, cpr);
        write_cfg(qcer_pkg::CFG_INVERT, {(qcer_pkg::CFG_DATA_W-1)'($urandom), inv});
    endtask

    task automatic directed_requests();
        // held speed right after reset, wrapped deltas at both extremes
        send_request(qcer_pkg::CMD_SPEED, 16'h0000, 32'h0000_0000);
        send_request(qcer_pkg::CMD_COUNT, 16'hFFFF, 32'h0000_0001);
        send_request(qcer_pkg::CMD_COUNT, 16'h7FFF, 32'h0000_0002);
        send_request(qcer_pkg::CMD_SPEED, 16'h8000, 32'hFFFF_FFFF);
        send_request(qcer_pkg::CMD_SPEED, 16'h8000, 32'hFFFF_FFFF);
        // init near the top of the tick range, then a speed across the wrap
        send_request(qcer_pkg::CMD_INIT,  16'h1234, 32'hFFFF_FFF0);
        send_request(qcer_pkg::CMD_SPEED, 16'h0100, 32'h0000_0005);
        send_request(qcer_pkg::CMD_RESET, 16'hABCD, 32'h0000_0007);
        send_request(qcer_pkg::CMD_COUNT, 16'h0000, 32'h0000_0000);
        // inverted half-range deltas, then clamp in both directions
        set_config(16'd1, 1'b1);
        send_request(qcer_pkg::CMD_COUNT, 16'h8000, 32'h0000_0006);
        send_request(qcer_pkg::CMD_COUNT, 16'h0000, 32'h0000_0006);
        send_request(qcer_pkg::CMD_COUNT, 16'h8000, 32'h0000_0006);
        send_request(qcer_pkg::CMD_SPEED, 16'h8000, 32'h0000_0006);
        send_request(qcer_pkg::CMD_COUNT, 16'hFFFF, 32'h0000_0007);
        send_request(qcer_pkg::CMD_COUNT, 16'h7FFE, 32'h0000_0007);
        send_request(qcer_pkg::CMD_COUNT, 16'hFFFD, 32'h0000_0007);
        send_request(qcer_pkg::CMD_SPEED, 16'hFFFD, 32'h0000_0007);
        // zero counts per revolution
        set_config(16'd0, 1'b0);
        send_request(qcer_pkg::CMD_COUNT, 16'h0005, 32'h0000_0008);
        send_request(qcer_pkg::CMD_SPEED, 16'h0005, 32'h0000_0064);
        send_request(qcer_pkg::CMD_SPEED, 16'h0005, 32'h0000_00C8);
        send_request(qcer_pkg::CMD_COUNT, 16'h0000, 32'h0000_00FA);
        send_request(qcer_pkg::CMD_SPEED, 16'h0000, 32'h0000_012C);
        // largest divisor
        set_config(16'hFFFF, 1'b0);
        send_request(qcer_pkg::CMD_INIT,  16'hFFFF, 32'h0000_0000);
        send_request(qcer_pkg::CMD_SPEED, 16'h0010, 32'hFFFF_FFFF);
    endtask

    // Mostly a moving encoder sampled with a running tick; the rest is noise.
    task automatic random_requests(input int count);
        int                         pick;
        int                         sel;
        logic [qcer_pkg::CMD_W-1:0] cmd;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
            begin
                if ($urandom_range(0, 15) == 0)
                    enc_vel = int'($urandom_range(0, 40)) - 20;
                else if ($urandom_range(0, 63) == 0)
                    enc_vel = int'($signed(16'($urandom)));
                enc_raw = enc_raw
                        + qcer_pkg::RAW_W'(enc_vel + int'($urandom_range(0, 2)) - 1);
                enc_ms = enc_ms + $urandom_range(0, 4);
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    cmd = qcer_pkg::CMD_COUNT;
                else if (sel < 95)
                    cmd = qcer_pkg::CMD_SPEED;
                else if (sel < 98)
                    cmd = qcer_pkg::CMD_RESET;
                else
                    cmd = qcer_pkg::CMD_INIT;
                send_request(cmd, enc_raw, enc_ms);
                // the block takes the counter as zeroed after reset or init
                if (cmd == qcer_pkg::CMD_RESET || cmd == qcer_pkg::CMD_INIT)
                    enc_raw = '0;
            end
            else
            begin
                cmd = qcer_pkg::CMD_W'($urandom_range(qcer_pkg::CMD_COUNT,
                                                      qcer_pkg::CMD_INIT));
                send_request(cmd, qcer_pkg::RAW_W'($urandom),
                             $urandom_range(0, 1) ? qcer_pkg::TIME_W'($urandom) : enc_ms);
            end
        end
    endtask

    initial
    begin
        int run_len;
        int stall_len;
        result_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 20);
            result_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= qcer_pkg::CFG_COUNTS_PER_REV;
        cfg_data <= '0;
        steady_run = 1'b0;
        enc_raw = '0;
        enc_ms = '0;
        enc_vel = 3;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        set_config(qcer_pkg::CPR_RESET, 1'b0);
        random_requests(250);

        set_config(16'd1, 1'b1);
        random_requests(200);

        // first half back to back on both sides
        set_config(16'hFFFF, 1'b1);
        steady_run = 1'b1;
        random_requests(100);
        steady_run = 1'b0;
        random_requests(100);

        set_config(16'd0, 1'b0);
        random_requests(100);

        set_config(qcer_pkg::CPR_W'($urandom_range(1, 65535)), 1'($urandom));
        random_requests(150);
        drain();
        random_requests(150);

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
